### hw/rtl/fsw_pkg.sv
// Shared types and constants for the fisheye sphere warp block.
// Used by every module under hw/rtl; it depends on nothing else.
package fsw_pkg;

    // Widths fixed by the field widths of the item and configuration ports
    localparam int COORD_W     = 9;     // pixel row / column
    localparam int DIM_W       = 10;    // effective image size
    localparam int HALF_W      = 9;     // centre coordinate
    localparam int OFS_W       = 10;    // signed offset from the centre
    localparam int SQ_W        = 18;    // square of one offset
    localparam int RC2_W       = 16;    // circle radius squared
    localparam int R2_W        = 16;    // radius squared of a pixel inside the circle
    localparam int RMAX2_W     = 19;    // sum of the squared centre coordinates
    localparam int GAIN_W      = 12;
    localparam int GAIN_FRAC   = 8;
    localparam int NUM_W       = GAIN_W + R2_W;
    localparam int DEN_W       = RMAX2_W + GAIN_FRAC;
    localparam int CHAN_W      = 8;
    localparam int RGB_W       = 3 * CHAN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTORTION_GAIN = 2'd2;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              mapped;
    } rsp_t;

    // Geometry derived from the configuration registers
    typedef struct packed {
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [HALF_W-1:0] ri;
        logic [HALF_W-1:0] rj;
        logic [RC2_W-1:0]  rc2;
        logic [DEN_W-1:0]  den;
        logic [GAIN_W-1:0] gain;
    } geom_t;

    // Classified item passed from the front end to the back end
    typedef struct packed {
        logic               mode;
        logic               in_circle;
        logic [OFS_W-1:0]   x;
        logic [OFS_W-1:0]   y;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RGB_W-1:0]   rgb;
        logic [R2_W-1:0]    r2;
    } item_t;

endpackage

### hw/rtl/fsw_front.sv
// Front end of the fisheye sphere warp: takes items, works out the offset from
// the centre and the squared radius, and classifies each query as inside or not.
// Depends on fsw_pkg.
module fsw_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  fsw_pkg::req_t  req,
    input  fsw_pkg::geom_t geom,
    output logic           push,
    output fsw_pkg::item_t push_item,
    input  logic           full
);
    import fsw_pkg::*;

    logic                        enable;
    logic                        f1_valid_reg;
    item_t                       f1_item_reg;
    logic                        f1_in_img_reg;
    logic                        f2_valid_reg;
    item_t                       f2_item_reg;
    logic                        f2_in_img_reg;
    logic [SQ_W-1:0]             f2_x_sq_reg;
    logic [SQ_W-1:0]             f2_y_sq_reg;
    logic [OFS_W-1:0]            x_ofs;
    logic [OFS_W-1:0]            y_ofs;
    logic                        in_img;
    logic signed [2*OFS_W-1:0]   x_sq;
    logic signed [2*OFS_W-1:0]   y_sq;
    logic [RMAX2_W-1:0]          r2_full;

    // The whole front end holds while the queue has no room.
    assign enable    = !full;
    assign req_stall = full;

    always_comb
    begin
        x_ofs  = OFS_W'({1'b0, req.pixel_col}) - OFS_W'({1'b0, geom.rj});
        y_ofs  = OFS_W'({1'b0, req.pixel_row}) - OFS_W'({1'b0, geom.ri});
        in_img = ({1'b0, req.pixel_row} < geom.rows) && ({1'b0, req.pixel_col} < geom.cols);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            f1_valid_reg <= req_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            f1_item_reg.mode      <= req.mode;
            f1_item_reg.in_circle <= 1'b0;
            f1_item_reg.x         <= x_ofs;
            f1_item_reg.y         <= y_ofs;
            f1_item_reg.row       <= req.pixel_row;
            f1_item_reg.col       <= req.pixel_col;
            f1_item_reg.rgb       <= {req.in_red, req.in_green, req.in_blue};
            f1_item_reg.r2        <= '0;
            f1_in_img_reg         <= in_img;

            f2_item_reg        <= f1_item_reg;
            f2_in_img_reg      <= f1_in_img_reg;
            f2_x_sq_reg        <= x_sq[SQ_W-1:0];
            f2_y_sq_reg        <= y_sq[SQ_W-1:0];
        end
    end

    always_comb
    begin
        x_sq = $signed(f1_item_reg.x) * $signed(f1_item_reg.x);
        y_sq = $signed(f1_item_reg.y) * $signed(f1_item_reg.y);
    end

    // Only a query strictly inside the circle and inside the image is warped.
    always_comb
    begin
        r2_full             = {1'b0, f2_x_sq_reg} + {1'b0, f2_y_sq_reg};
        push_item           = f2_item_reg;
        push_item.in_circle = (f2_item_reg.mode == MODE_QUERY) && f2_in_img_reg
                              && (RMAX2_W'(geom.rc2) > r2_full);
        push_item.r2        = r2_full[R2_W-1:0];
        push                = f2_valid_reg && enable;
    end

endmodule

### hw/rtl/fsw_queue.sv
// Short queue between the front and back ends of the fisheye sphere warp.
// Depends on fsw_pkg.
module fsw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fsw_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output fsw_pkg::item_t pop_item,
    output logic           empty
);
    import fsw_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("transfer into a full queue");

    a_count_rise: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count failed to follow a lone push");
`endif

endmodule

### hw/rtl/fsw_div.sv
// Pipelined restoring divider for the warp factor: one quotient bit per stage,
// with the classified item carried alongside. Depends on fsw_pkg.
module fsw_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  fsw_pkg::item_t            in_item,
    input  logic [fsw_pkg::NUM_W-1:0] dividend,
    input  logic [fsw_pkg::DEN_W-1:0] divisor,
    output logic                      out_valid,
    output fsw_pkg::item_t            out_item,
    output logic [FRAC_BITS:0]        quotient
);
    import fsw_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;
    localparam int QW     = FRAC_BITS + 1;

    logic [STAGES-1:0] valid_reg;
    item_t             item_reg [STAGES];
    logic [NUM_W-1:0]  rem_reg  [STAGES];
    logic [QW-1:0]     quo_reg  [STAGES];
    logic [NUM_W-1:0]  trial    [STAGES];
    logic [NUM_W-1:0]  rem_next [STAGES];
    logic [STAGES-1:0] take;
    logic [NUM_W-1:0]  den_ext;

    assign den_ext = NUM_W'(divisor);

    // The first stage yields the integer bit; the dividend stays below twice
    // the divisor for any pixel inside the circle, so one integer bit is enough.
    always_comb
    begin
        trial[0] = dividend;
        for (int s = 1; s < STAGES; s++)
        begin
            trial[s] = {rem_reg[s-1][NUM_W-2:0], 1'b0};
        end
        for (int s = 0; s < STAGES; s++)
        begin
            take[s]     = (trial[s] >= den_ext);
            rem_next[s] = take[s] ? trial[s] - den_ext : trial[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= in_item;
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= QW'(take[0]);
            for (int s = 1; s < STAGES; s++)
            begin
                item_reg[s] <= item_reg[s-1];
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= {quo_reg[s-1][QW-2:0], take[s]};
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign quotient  = quo_reg[STAGES-1];

endmodule

### hw/rtl/fsw_back.sv
// Back end of the fisheye sphere warp: factor division, coordinate scaling,
// frame store access and the output register. Depends on fsw_pkg and fsw_div.
module fsw_back #(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 512,
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fsw_pkg::geom_t geom,
    output logic           pop,
    input  fsw_pkg::item_t pop_item,
    input  logic           empty,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fsw_pkg::rsp_t  rsp
);
    import fsw_pkg::*;

    localparam int FW     = FRAC_BITS + 2;
    localparam int PW     = HALF_W + FW;
    localparam int SW     = FRAC_BITS + 13;
    localparam int UW     = SW - 1 - FRAC_BITS;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                   adv;
    logic                   b0_valid_reg;
    item_t                  b0_item_reg;
    logic [NUM_W-1:0]       b0_num_reg;
    logic                   dv_valid;
    item_t                  dv_item;
    logic [FRAC_BITS:0]     dv_quo;
    logic [FW-1:0]          factor;
    logic [HALF_W-1:0]      mag_x;
    logic [HALF_W-1:0]      mag_y;
    logic                   m1_valid_reg;
    item_t                  m1_item_reg;
    logic [PW-1:0]          m1_prod_x_reg;
    logic [PW-1:0]          m1_prod_y_reg;
    logic                   m1_neg_x_reg;
    logic                   m1_neg_y_reg;
    logic signed [SW-1:0]   sum_x_next;
    logic signed [SW-1:0]   sum_y_next;
    logic                   m2_valid_reg;
    item_t                  m2_item_reg;
    logic signed [SW-1:0]   m2_sum_x_reg;
    logic signed [SW-1:0]   m2_sum_y_reg;
    logic [UW:0]            res_x;
    logic [UW:0]            res_y;
    logic                   hit;
    logic                   load_ok;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   store_wr;
    logic                   store_rd;
    logic [RGB_W-1:0]       frame_store [DEPTH];
    logic [RGB_W-1:0]       rd_data_reg;
    logic                   m4_valid_reg;
    logic                   m4_query_reg;
    logic                   m4_hit_reg;
    logic                   out_valid_reg;
    rsp_t                   out_item_reg;

    // Split a scaled coordinate into its whole part, truncated toward zero,
    // and whether it lands inside 0 .. limit-1.
    function automatic logic [UW:0] resolve(input logic signed [SW-1:0] sum,
                                            input logic [DIM_W-1:0] limit);
        logic [SW-1:0] mag;
        logic [UW-1:0] whole;
        logic          ok;
        if (sum[SW-1])
        begin
            mag   = -sum;
            whole = '0;
            ok    = (mag[SW-1:FRAC_BITS] == '0);
        end
        else
        begin
            mag   = sum;
            whole = mag[SW-2:FRAC_BITS];
            ok    = (whole < UW'(limit));
        end
        return {ok, whole};
    endfunction

    // The back end moves as one whenever the output register is free or being emptied.
    assign adv = !out_valid_reg || !rsp_stall;
    assign pop = adv && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg  <= !empty;
            m1_valid_reg  <= dv_valid;
            m2_valid_reg  <= m1_valid_reg;
            m4_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m4_valid_reg && m4_query_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_item_reg <= pop_item;
            b0_num_reg  <= NUM_W'(pop_item.r2) * NUM_W'(geom.gain);
        end
    end

    fsw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b0_valid_reg),
        .in_item   (b0_item_reg),
        .dividend  (b0_num_reg),
        .divisor   (geom.den),
        .out_valid (dv_valid),
        .out_item  (dv_item),
        .quotient  (dv_quo)
    );

    always_comb
    begin
        factor = {1'b0, dv_quo} + (FW'(1) << FRAC_BITS);
        mag_x  = dv_item.x[OFS_W-1] ? HALF_W'(-dv_item.x) : HALF_W'(dv_item.x);
        mag_y  = dv_item.y[OFS_W-1] ? HALF_W'(-dv_item.y) : HALF_W'(dv_item.y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_item_reg   <= dv_item;
            m1_prod_x_reg <= PW'(mag_x) * PW'(factor);
            m1_prod_y_reg <= PW'(mag_y) * PW'(factor);
            m1_neg_x_reg  <= dv_item.x[OFS_W-1];
            m1_neg_y_reg  <= dv_item.y[OFS_W-1];
        end
    end

    always_comb
    begin
        sum_x_next = $signed(SW'(m1_prod_x_reg));
        sum_y_next = $signed(SW'(m1_prod_y_reg));
        if (m1_neg_x_reg)
        begin
            sum_x_next = -sum_x_next;
        end
        if (m1_neg_y_reg)
        begin
            sum_y_next = -sum_y_next;
        end
        sum_x_next = sum_x_next + $signed(SW'(geom.rj) << FRAC_BITS);
        sum_y_next = sum_y_next + $signed(SW'(geom.ri) << FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_item_reg  <= m1_item_reg;
            m2_sum_x_reg <= sum_x_next;
            m2_sum_y_reg <= sum_y_next;
        end
    end

    always_comb
    begin
        res_x    = resolve(m2_sum_x_reg, geom.cols);
        res_y    = resolve(m2_sum_y_reg, geom.rows);
        hit      = m2_item_reg.in_circle && res_x[UW] && res_y[UW];
        load_ok  = (32'(m2_item_reg.row) < 32'(MAX_ROWS))
                   && (32'(m2_item_reg.col) < 32'(MAX_COLS));
        rd_addr  = ADDR_W'(ADDR_W'(res_y[UW-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(res_x[UW-1:0]));
        wr_addr  = ADDR_W'(ADDR_W'(m2_item_reg.row) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(m2_item_reg.col));
        store_wr = adv && m2_valid_reg && (m2_item_reg.mode == MODE_LOAD) && load_ok;
        store_rd = adv && m2_valid_reg && (m2_item_reg.mode == MODE_QUERY) && hit;
    end

    // One write port for loads and one registered read port for queries.
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            frame_store[wr_addr] <= m2_item_reg.rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_rd)
        begin
            rd_data_reg <= frame_store[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_query_reg <= (m2_item_reg.mode == MODE_QUERY);
            m4_hit_reg   <= hit;
            if (m4_hit_reg)
            begin
                out_item_reg <= {rd_data_reg, 1'b1};
            end
            else
            begin
                out_item_reg <= '0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

`ifndef NO_ASSERTIONS
    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.mapped |->
            rsp.out_red == '0 && rsp.out_green == '0 && rsp.out_blue == '0)
        else $error("unmapped result carries a non-zero colour");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && m4_valid_reg && !m4_query_reg |=> !out_valid_reg)
        else $error("a load produced a result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed before its transfer");
`endif

endmodule

### hw/rtl/fisheye_sphere_warp.sv
// Top level of the fisheye sphere warp: configuration registers, derived geometry,
// and the front end, queue and back end. Depends on fsw_pkg, fsw_front, fsw_queue,
// fsw_back and fsw_div.
//
// Load items write one RGB pixel into an on-chip frame store of MAX_ROWS x MAX_COLS
// entries; query items return the source pixel that the barrel warp maps onto the
// named output pixel, or zeros with mapped low. One item is taken per clock while
// req_stall is low, loads and queries in any mix; a query's result is registered in
// the front end, the queue and the back end, the bulk of its path being the factor
// divider, which resolves one quotient bit per pipeline stage. The frame store has
// one write and one read port, used by at most one item each cycle, and it is not
// cleared: a query that lands on a pixel never loaded returns an undefined colour.
// Configuration writes are taken at once and must only be made while no item is in
// flight; after a write the derived squares and then the divisor are registered.
module fisheye_sphere_warp #(
    parameter int MAX_COLS         = 512,
    parameter int MAX_ROWS         = 512,
    parameter int FACTOR_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  fsw_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output fsw_pkg::rsp_t                  rsp
);
    import fsw_pkg::*;

    logic [DIM_W-1:0]   cols_cfg_reg;
    logic [DIM_W-1:0]   rows_cfg_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [DIM_W-1:0]   cols_eff;
    logic [DIM_W-1:0]   rows_eff;
    logic [HALF_W-1:0]  ri;
    logic [HALF_W-1:0]  rj;
    logic [DIM_W-1:0]   rc_sum;
    logic [RC2_W-1:0]   rc2_reg;
    logic [SQ_W-1:0]    ri2_reg;
    logic [SQ_W-1:0]    rj2_reg;
    logic [RMAX2_W-1:0] rmax2;
    logic [DEN_W-1:0]   den_reg;
    geom_t              geom;
    logic               q_push;
    item_t              q_push_item;
    logic               q_full;
    logic               q_pop;
    item_t              q_pop_item;
    logic               q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= DIM_W'(512);
            rows_cfg_reg <= DIM_W'(512);
            gain_reg     <= GAIN_W'(768);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_COLS:      cols_cfg_reg <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_ROWS:      rows_cfg_reg <= cfg_data[DIM_W-1:0];
                CFG_DISTORTION_GAIN: gain_reg     <= cfg_data[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // Sizes in use are clamped to the frame store, and a size of zero is taken as one.
    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            cols_eff = DIM_W'(1);
        end
        else if (32'(cols_cfg_reg) > 32'(MAX_COLS))
        begin
            cols_eff = DIM_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = cols_cfg_reg;
        end

        if (rows_cfg_reg == '0)
        begin
            rows_eff = DIM_W'(1);
        end
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = DIM_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_cfg_reg;
        end

        ri     = rows_eff[DIM_W-1:1];
        rj     = cols_eff[DIM_W-1:1];
        rc_sum = {1'b0, ri} + {1'b0, rj};
        rmax2  = {1'b0, ri2_reg} + {1'b0, rj2_reg};
    end

    // The squared terms are needed only some stages after a transfer, so they
    // are registered and follow the configuration registers continuously.
    always_ff @(posedge clk)
    begin
        rc2_reg <= RC2_W'(rc_sum[DIM_W-1:2]) * RC2_W'(rc_sum[DIM_W-1:2]);
        ri2_reg <= SQ_W'(ri) * SQ_W'(ri);
        rj2_reg <= SQ_W'(rj) * SQ_W'(rj);
        den_reg <= {rmax2, {GAIN_FRAC{1'b0}}};
    end

    always_comb
    begin
        geom.cols = cols_eff;
        geom.rows = rows_eff;
        geom.ri   = ri;
        geom.rj   = rj;
        geom.rc2  = rc2_reg;
        geom.den  = den_reg;
        geom.gain = gain_reg;
    end

    fsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .geom      (geom),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full)
    );

    fsw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    fsw_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
